@@ sv/infix_to_postfix_converter_assert.svh @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_assert.svh
// Assertion macros shared by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, disabled during reset.
`define IPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ sv/ipc_pkg.sv @@
// ----------------------------------------------------------------------------
// ipc_pkg
// Types, character codes and precedence helpers for the infix-to-postfix block.
// ----------------------------------------------------------------------------
`default_nettype none

package ipc_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;
  localparam int ERR_W       = 2;

  localparam logic [SYM_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [SYM_W-1:0] CH_PCT    = 8'h25;
  localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [SYM_W-1:0] CH_LOW_A  = 8'h61;
  localparam logic [SYM_W-1:0] CH_LOW_Z  = 8'h7A;
  localparam logic [SYM_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [SYM_W-1:0] CH_UP_Z   = 8'h5A;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE,
    ERR_UNMATCHED_CLOSE,
    ERR_OVERFLOW,
    ERR_UNCLOSED_OPEN
  } err_t;

  typedef enum logic [1:0] {
    STK_HOLD,
    STK_PUSH,
    STK_POP
  } stk_op_t;

  typedef struct packed {
    stk_op_t          op;
    logic [SYM_W-1:0] push_sym;
  } stk_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  function automatic logic is_letter(input logic [SYM_W-1:0] c);
    return ((c >= CH_LOW_A) && (c <= CH_LOW_Z)) || ((c >= CH_UP_A) && (c <= CH_UP_Z));
  endfunction

  function automatic logic [1:0] prec_of(input logic [SYM_W-1:0] c);
    logic [1:0] p;
    if (c == CH_CARET) begin
      p = 2'd3;
    end else if ((c == CH_STAR) || (c == CH_SLASH) || (c == CH_PCT)) begin
      p = 2'd2;
    end else begin
      p = 2'd1;
    end
    return p;
  endfunction

  // Stacked operator 'top' is popped by an incoming operator of precedence p.
  // Caret is right-associative, so equal precedence only pops below level 3.
  function automatic logic pops_over(input logic [SYM_W-1:0] top, input logic [1:0] p);
    logic [1:0] q;
    q = prec_of(top);
    return (q > p) || ((q == p) && (q != 2'd3));
  endfunction

endpackage

`default_nettype wire

@@ sv/ipc_cell.sv @@
// ----------------------------------------------------------------------------
// ipc_cell
// One entry of the shift-register operator stack.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_cell (
  input  wire logic                        clk,
  input  wire ipc_pkg::stk_op_t            op,
  input  wire logic [ipc_pkg::SYM_W-1:0]   above,
  input  wire logic [ipc_pkg::SYM_W-1:0]   below,
  output logic      [ipc_pkg::SYM_W-1:0]   value
);
  import ipc_pkg::*;

  // push shifts entries away from the top, pop shifts them toward it
  always_ff @(posedge clk) begin
    case (op)
      STK_PUSH: value <= above;
      STK_POP:  value <= below;
      default:  value <= value;
    endcase
  end

endmodule

`default_nettype wire

@@ sv/ipc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ipc_ctrl
// Shunting-yard sequencer: input capture, stack control and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ipc_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ipc_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic                        end_of_expression,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ipc_pkg::SYM_W-1:0]   out_symbol,
  output logic                             symbol_valid,
  output logic                             last_of_run,
  output logic                             expr_done,
  output logic      [ipc_pkg::ERR_W-1:0]   error_code,
  input  wire logic [ipc_pkg::SYM_W-1:0]   top_sym,
  input  wire logic [ipc_pkg::SYM_W-1:0]   next_sym,
  output ipc_pkg::stk_ctrl_t               stk
);
  import ipc_pkg::*;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count;
  err_t              sticky;
  logic [SYM_W-1:0]  cur_sym;
  logic              cur_end;

  logic              emit, emit_last, emit_term, do_pop, do_push, flag, done;
  logic [SYM_W-1:0]  emit_sym;
  err_t              flag_code;
  logic [1:0]        cur_prec;
  logic              has_top, has_next, full, stall, go;

  assign cur_prec = prec_of(cur_sym);
  assign has_top  = (count != '0);
  assign has_next = (count > CNT_W'(1));
  assign full     = (count == CNT_W'(STACK_DEPTH));
  assign stall    = emit && out_valid && !out_ready;
  assign go       = (state == ST_RUN) && !stall;

  // one step of the current item per cycle while the output does not stall
  always_comb begin
    emit      = 1'b0;
    emit_sym  = '0;
    emit_last = 1'b0;
    emit_term = 1'b0;
    do_pop    = 1'b0;
    do_push   = 1'b0;
    flag      = 1'b0;
    flag_code = ERR_NONE;
    done      = 1'b0;
    if (cur_end) begin
      if (has_top) begin
        do_pop = 1'b1;
        if (top_sym == CH_LPAREN) begin
          flag      = 1'b1;
          flag_code = ERR_UNCLOSED_OPEN;
        end else begin
          emit     = 1'b1;
          emit_sym = top_sym;
        end
      end else begin
        emit      = 1'b1;
        emit_term = 1'b1;
        emit_last = 1'b1;
        done      = 1'b1;
      end
    end else if (is_letter(cur_sym)) begin
      emit      = 1'b1;
      emit_sym  = cur_sym;
      emit_last = 1'b1;
      done      = 1'b1;
    end else if (cur_sym == CH_LPAREN) begin
      done = 1'b1;
      if (full) begin
        flag      = 1'b1;
        flag_code = ERR_OVERFLOW;
      end else begin
        do_push = 1'b1;
      end
    end else if (cur_sym == CH_RPAREN) begin
      if (!has_top) begin
        flag      = 1'b1;
        flag_code = ERR_UNMATCHED_CLOSE;
        done      = 1'b1;
      end else if (top_sym == CH_LPAREN) begin
        do_pop = 1'b1;
        done   = 1'b1;
      end else begin
        do_pop    = 1'b1;
        emit      = 1'b1;
        emit_sym  = top_sym;
        emit_last = !has_next || (next_sym == CH_LPAREN);
      end
    end else begin
      if (has_top && (top_sym != CH_LPAREN) && pops_over(top_sym, cur_prec)) begin
        do_pop    = 1'b1;
        emit      = 1'b1;
        emit_sym  = top_sym;
        // last pop when the entry below will not be popped too
        emit_last = !(has_next && (next_sym != CH_LPAREN) && pops_over(next_sym, cur_prec));
      end else begin
        done = 1'b1;
        if (full) begin
          flag      = 1'b1;
          flag_code = ERR_OVERFLOW;
        end else begin
          do_push = 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (state)
      ST_IDLE: state_next = in_valid ? ST_RUN : ST_IDLE;
      ST_RUN:  state_next = (go && done) ? ST_IDLE : ST_RUN;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = (state == ST_IDLE);
    stk.push_sym = cur_sym;
    if (go && do_push) begin
      stk.op = STK_PUSH;
    end else if (go && do_pop) begin
      stk.op = STK_POP;
    end else begin
      stk.op = STK_HOLD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      sticky    <= ERR_NONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (go && do_push) begin
        count <= count + CNT_W'(1);
      end else if (go && do_pop) begin
        count <= count - CNT_W'(1);
      end
      if (go && emit_term) begin
        sticky <= ERR_NONE;
      end else if (go && flag && (sticky == ERR_NONE)) begin
        sticky <= flag_code;
      end
      if (go && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_sym <= in_symbol;
      cur_end <= end_of_expression;
    end
    if (go && emit) begin
      out_symbol   <= emit_sym;
      symbol_valid <= !emit_term;
      last_of_run  <= emit_last;
      expr_done    <= emit_term;
      error_code   <= emit_term ? sticky : ERR_NONE;
    end
  end

endmodule

`default_nettype wire

@@ sv/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard infix to postfix converter, one character item at a time.
// ----------------------------------------------------------------------------
// Operation: an item is taken while the sequencer is idle. It then spends a
// step on each stack entry it pops (one result each, except a '(' dropped at
// the end) and a closing step: the letter's result, the push, the pop of the
// matching '(', the error flag or the terminator. The operator stack is a row
// of STACK_DEPTH shift cells that moves one entry per cycle when the output
// does not stall; that pop rate sets throughput. A finished result sits in an
// output register, so the next item can be taken while it waits. An output
// stall holds the sequencer until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_to_postfix_converter (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [ipc_pkg::SYM_W-1:0]   in_symbol,
  input  wire logic                        end_of_expression,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic      [ipc_pkg::SYM_W-1:0]   out_symbol,
  output logic                             symbol_valid,
  output logic                             last_of_run,
  output logic                             expr_done,
  output logic      [ipc_pkg::ERR_W-1:0]   error_code
);
  import ipc_pkg::*;

  stk_ctrl_t         stk;
  logic [SYM_W-1:0]  stack_q [STACK_DEPTH];

  ipc_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_symbol         (in_symbol),
    .end_of_expression (end_of_expression),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_symbol        (out_symbol),
    .symbol_valid      (symbol_valid),
    .last_of_run       (last_of_run),
    .expr_done         (expr_done),
    .error_code        (error_code),
    .top_sym           (stack_q[0]),
    .next_sym          (stack_q[1]),
    .stk               (stk)
  );

  // cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [SYM_W-1:0] above, below;
    if (i == 0) begin : g_top
      assign above = stk.push_sym;
    end else begin : g_mid
      assign above = stack_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = stack_q[i];
    end else begin : g_up
      assign below = stack_q[i+1];
    end
    ipc_cell u_cell (
      .clk   (clk),
      .op    (stk.op),
      .above (above),
      .below (below),
      .value (stack_q[i])
    );
  end

endmodule

`default_nettype wire

@@ sv/infix_to_postfix_converter_checker.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_checker
// Port-level checks on the converter's result stream and input handshake.
// ----------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_assert.svh"

module infix_to_postfix_converter_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [ipc_pkg::SYM_W-1:0]   out_symbol,
  input  wire logic                        symbol_valid,
  input  wire logic                        last_of_run,
  input  wire logic                        expr_done,
  input  wire logic [ipc_pkg::ERR_W-1:0]   error_code
);
  import ipc_pkg::*;

  // a waiting result holds
  `IPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_symbol) && $stable(last_of_run))

  // the terminator always closes its run and carries no character
  `IPC_ASSERT_IMPLY(a_term_shape, clk, rst, out_valid && expr_done, last_of_run && !symbol_valid && (out_symbol == '0))

  // ordinary results carry a character and no error
  `IPC_ASSERT_IMPLY(a_sym_shape, clk, rst, out_valid && !expr_done, symbol_valid && (error_code == ERR_W'(ERR_NONE)))

  // an item is still being worked on in the cycle after it is taken
  `IPC_ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)

endmodule

bind infix_to_postfix_converter infix_to_postfix_converter_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_symbol   (out_symbol),
  .symbol_valid (symbol_valid),
  .last_of_run  (last_of_run),
  .expr_done    (expr_done),
  .error_code   (error_code)
);

`default_nettype wire

@@ dv/tb_infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// tb_infix_to_postfix_converter
// Self-checking bench for the shunting-yard converter. A short directed table
// covers letter bounds, every precedence class, associativity, unmatched-close
// and unclosed-open errors, then random expressions (well-formed, broken,
// noise and deep nests) run under random input gaps and output stalls. Every
// output item is checked against an in-bench operator-stack predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_infix_to_postfix_converter;
  timeunit 1ns;
  timeprecision 1ps;

  import ipc_pkg::*;

  localparam int RAND_ITEMS     = 430;
  localparam int SETTLE_CYCLES  = 48;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 5_000_000;
  localparam int MAX_REPORTS    = 10;

  // operator bytes that are not in the package
  localparam logic [SYM_W-1:0] CH_PLUS     = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS    = 8'h2D;
  localparam logic [SYM_W-1:0] CH_AMP      = 8'h26;
  localparam logic [SYM_W-1:0] CH_BAR      = 8'h7C;
  localparam logic [SYM_W-1:0] CH_AT       = 8'h40;
  localparam logic [SYM_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [SYM_W-1:0] CH_BACKTICK = 8'h60;
  localparam logic [SYM_W-1:0] CH_LBRACE   = 8'h7B;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             valid;
    logic             last;
    logic             done;
    err_t             err;
  } postfix_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             eoe;
  } char_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             eoe;
    logic             pinned;
    logic [SYM_W-1:0] pin_sym;
    err_t             pin_err;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [SYM_W-1:0] in_symbol = '0;
  logic             end_of_expression = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [SYM_W-1:0] out_symbol;
  logic             symbol_valid;
  logic             last_of_run;
  logic             expr_done;
  logic [ERR_W-1:0] error_code;

  infix_to_postfix_converter dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_symbol         (in_symbol),
    .end_of_expression (end_of_expression),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_symbol        (out_symbol),
    .symbol_valid      (symbol_valid),
    .last_of_run       (last_of_run),
    .expr_done         (expr_done),
    .error_code        (error_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [SYM_W-1:0] opstack [STACK_DEPTH];
  int unsigned      opcount;
  err_t             expr_err;

  postfix_t   postfix_q [$];
  char_item_t burst_q [$];
  postfix_t   want_res;
  int         mismatches;
  longint     cycles;
  bit         calm;
  bit         rx_hold;
  int         rx_left;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic int op_rank(input logic [SYM_W-1:0] c);
    if (c == CH_CARET) return 3;
    if (c == CH_STAR || c == CH_SLASH || c == CH_PCT) return 2;
    return 1;
  endfunction

  function automatic void flag_err(input err_t e);
    if (expr_err == ERR_NONE) expr_err = e;
  endfunction

  function automatic void add_result(input logic [SYM_W-1:0] sym, input logic valid,
                                     input logic done, input err_t err, inout int n);
    postfix_t r;
    r.sym   = sym;
    r.valid = valid;
    r.last  = 1'b0;
    r.done  = done;
    r.err   = err;
    postfix_q.push_back(r);
    n++;
  endfunction

  function automatic void push_op(input logic [SYM_W-1:0] c);
    if (opcount < STACK_DEPTH) begin
      opstack[opcount] = c;
      opcount++;
    end else begin
      flag_err(ERR_OVERFLOW);
    end
  endfunction

  // Works out the output items caused by one accepted input item.
  task automatic convert_item(input logic [SYM_W-1:0] c, input logic eoe,
                              output int n, output postfix_t tail);
    logic [SYM_W-1:0] top;
    bit matched;
    int p;
    n = 0;
    if (eoe) begin
      while (opcount > 0) begin
        opcount--;
        top = opstack[opcount];
        if (top == CH_LPAREN) flag_err(ERR_UNCLOSED_OPEN);
        else add_result(top, 1'b1, 1'b0, ERR_NONE, n);
      end
      add_result('0, 1'b0, 1'b1, expr_err, n);
      opcount  = 0;
      expr_err = ERR_NONE;
    end else if ((c >= CH_LOW_A && c <= CH_LOW_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
      add_result(c, 1'b1, 1'b0, ERR_NONE, n);
    end else if (c == CH_LPAREN) begin
      push_op(c);
    end else if (c == CH_RPAREN) begin
      matched = 1'b0;
      while (opcount > 0 && !matched) begin
        opcount--;
        top = opstack[opcount];
        if (top == CH_LPAREN) matched = 1'b1;
        else add_result(top, 1'b1, 1'b0, ERR_NONE, n);
      end
      if (!matched) flag_err(ERR_UNMATCHED_CLOSE);
    end else begin
      p = op_rank(c);
      // pop while top binds tighter, or equally and left-associative
      while (opcount > 0 && opstack[opcount-1] != CH_LPAREN &&
             (op_rank(opstack[opcount-1]) > p ||
              (op_rank(opstack[opcount-1]) == p && p <= 2))) begin
        add_result(opstack[opcount-1], 1'b1, 1'b0, ERR_NONE, n);
        opcount--;
      end
      push_op(c);
    end
    if (n > 0) postfix_q[$].last = 1'b1;
    tail = (n > 0) ? postfix_q[$] : '0;
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what);
    if (mismatches < MAX_REPORTS) $display("mismatch: %s", what);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        note_mismatch($sformatf("unexpected item sym=%02h v=%0d last=%0d done=%0d err=%0d",
                                out_symbol, symbol_valid, last_of_run, expr_done,
                                error_code));
      end else begin
        want_res = postfix_q.pop_front();
        if (out_symbol !== want_res.sym || symbol_valid !== want_res.valid ||
            last_of_run !== want_res.last || expr_done !== want_res.done ||
            error_code !== want_res.err) begin
          note_mismatch($sformatf({"exp sym=%02h v=%0d last=%0d done=%0d err=%0d, ",
                                   "got sym=%02h v=%0d last=%0d done=%0d err=%0d"},
                                  want_res.sym, want_res.valid, want_res.last,
                                  want_res.done, want_res.err, out_symbol, symbol_valid,
                                  last_of_run, expr_done, error_code));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    rx_left = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_left > 0) begin
        rx_left--;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        rx_left = $urandom_range(1, 12);
      end else begin
        out_ready <= 1'b0;
        rx_left = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [SYM_W-1:0] sym, input logic eoe,
                           output int n, output postfix_t tail);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_symbol         <= sym;
    end_of_expression <= eoe;
    do @(posedge clk); while (!in_ready);
    convert_item(sym, eoe, n, tail);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_sym(input logic [SYM_W-1:0] sym, input logic eoe);
    char_item_t it;
    it.sym = sym;
    it.eoe = eoe;
    burst_q.push_back(it);
  endfunction

  function automatic logic [SYM_W-1:0] pick_letter();
    if ($urandom_range(0, 1)) return SYM_W'($urandom_range(CH_LOW_A, CH_LOW_Z));
    return SYM_W'($urandom_range(CH_UP_A, CH_UP_Z));
  endfunction

  function automatic logic [SYM_W-1:0] pick_op();
    case ($urandom_range(0, 7))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PCT;
      5:       return CH_CARET;
      6:       return CH_AMP;
      default: return CH_BAR;
    endcase
  endfunction

  task automatic gen_expr(input int lvl);
    gen_term(lvl);
    repeat ($urandom_range(0, 3)) begin
      queue_sym(pick_op(), 1'b0);
      gen_term(lvl);
    end
  endtask

  task automatic gen_term(input int lvl);
    if (lvl < 4 && $urandom_range(0, 3) == 0) begin
      queue_sym(CH_LPAREN, 1'b0);
      gen_expr(lvl + 1);
      queue_sym(CH_RPAREN, 1'b0);
    end else begin
      queue_sym(pick_letter(), 1'b0);
    end
  endtask

  task automatic build_burst();
    int r;
    int depth;
    int style;
    int pos;
    char_item_t it;
    burst_q.delete();
    r = $urandom_range(0, 99);
    if (r < 60) begin
      gen_expr(0);
      queue_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
    end else if (r < 72) begin
      // broken nesting: stray paren or a dropped character
      gen_expr(0);
      pos = $urandom_range(0, burst_q.size() - 1);
      it.eoe = 1'b0;
      case ($urandom_range(0, 2))
        0: begin it.sym = CH_LPAREN; burst_q.insert(pos, it); end
        1: begin it.sym = CH_RPAREN; burst_q.insert(pos, it); end
        default: burst_q.delete(pos);
      endcase
      queue_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
    end else if (r < 82) begin
      repeat ($urandom_range(1, 8)) queue_sym(SYM_W'($urandom_range(0, 255)), 1'b0);
      if ($urandom_range(0, 1)) queue_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
    end else if (r < 90) begin
      // nest up to and past a full stack
      depth = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 3);
      style = $urandom_range(0, 2);
      repeat (depth) begin
        if (style == 0 || (style == 2 && $urandom_range(0, 1))) queue_sym(CH_LPAREN, 1'b0);
        else queue_sym(CH_CARET, 1'b0);
      end
      queue_sym(pick_letter(), 1'b0);
      repeat ($urandom_range(0, depth)) queue_sym(CH_RPAREN, 1'b0);
      queue_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
    end else begin
      if ($urandom_range(0, 1)) queue_sym(pick_letter(), 1'b0);
      queue_sym(SYM_W'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  dir_row_t dir_rows [25] = '{
    '{CH_LOW_A,    1'b0, 1'b1, CH_LOW_A, ERR_NONE},
    '{CH_UP_Z,     1'b0, 1'b1, CH_UP_Z,  ERR_NONE},
    '{CH_BACKTICK, 1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_UP_A,     1'b0, 1'b1, CH_UP_A,  ERR_NONE},
    '{CH_LBRACE,   1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_LOW_Z,    1'b0, 1'b1, CH_LOW_Z, ERR_NONE},
    '{CH_STAR,     1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_AT,       1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_LBRACKET, 1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_LPAREN,   1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_UP_A,     1'b0, 1'b1, CH_UP_A,  ERR_NONE},
    '{CH_CARET,    1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_CARET,    1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_SLASH,    1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_PCT,      1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_RPAREN,   1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_RPAREN,   1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{8'h00,       1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{8'hFF,       1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{8'hA5,       1'b1, 1'b1, 8'h00,    ERR_UNMATCHED_CLOSE},
    '{8'h00,       1'b1, 1'b1, 8'h00,    ERR_NONE},
    '{CH_LPAREN,   1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{CH_LOW_Z,    1'b0, 1'b1, CH_LOW_Z, ERR_NONE},
    '{CH_PLUS,     1'b0, 1'b0, 8'h00,    ERR_NONE},
    '{8'hFF,       1'b1, 1'b1, 8'h00,    ERR_UNCLOSED_OPEN}
  };

  initial begin
    int n;
    int rand_items;
    int bursts;
    postfix_t tail;
    opcount    = 0;
    expr_err   = ERR_NONE;
    mismatches = 0;
    cycles     = 0;
    calm       = 1'b0;
    rx_hold    = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].sym, dir_rows[i].eoe, n, tail);
      if (dir_rows[i].pinned &&
          (n == 0 || tail.sym != dir_rows[i].pin_sym || tail.err != dir_rows[i].pin_err))
        note_mismatch($sformatf("row %0d: typed sym=%02h err=%0d, predicted sym=%02h err=%0d",
                                i, dir_rows[i].pin_sym, dir_rows[i].pin_err, tail.sym,
                                tail.err));
    end
    drain_results();

    rand_items = 0;
    bursts     = 0;
    while (rand_items < RAND_ITEMS) begin
      // long output hold-off while the input keeps offering items
      if (bursts == 40) rx_hold = 1'b1;
      calm = (bursts >= 120 && bursts < 150);
      if (bursts == 200) drain_results();
      build_burst();
      foreach (burst_q[i]) begin
        send_item(burst_q[i].sym, burst_q[i].eoe, n, tail);
        rand_items++;
      end
      bursts++;
    end
    drain_results();

    if (mismatches == 0 && postfix_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ infix_to_postfix_converter.f @@
+incdir+sv
sv/ipc_pkg.sv
sv/ipc_cell.sv
sv/ipc_ctrl.sv
sv/infix_to_postfix_converter.sv
sv/infix_to_postfix_converter_checker.sv
dv/tb_infix_to_postfix_converter.sv
